>>> src/mcasi_pkg.sv
package mcasi_pkg;

  localparam int CH_W         = 3;
  localparam int NUM_INPUT_CH = 1 << CH_W;
  localparam int SAMPLE_W     = 16;
  localparam int WEIGHT_W     = 9;
  localparam int NUM_WEIGHTS  = 8;
  localparam int CFG_IDX_W    = 3;
  localparam int SUM_W        = 64;
  localparam int COUNT_W      = 32;

  localparam int IN_TDATA_W   = 16;
  localparam int IN_TUSER_W   = CH_W;
  localparam int OUT_TDATA_W  = 2 * SAMPLE_W + SUM_W + COUNT_W;
  localparam int OUT_TUSER_W  = CH_W + 1;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic [SUM_W-1:0]    sum;
    logic                rate;
    logic [SAMPLE_W-1:0] smoothed;
    logic [SAMPLE_W-1:0] raw;
    logic [CH_W-1:0]     channel;
  } result_t;

endpackage

>>> src/multichannel_adc_smoother_integrator.sv
// Channel   Direction  Fields (lowest bit first)
// s_axis    in         tuser: channel[2:0]; tdata: sample[15:0]
// m_axis    out        tuser: out_channel[2:0], is_rate_channel[3];
//                      tdata: raw_value[15:0], smoothed_value[31:16],
//                             running_sum[95:32], sample_count[127:96]
// cfg       in         cfg_index selects weight_ch0..7, cfg_data is the weight
//
// One sample is accepted per cycle unless the output stalls; results are registered.
// The input register feeds one read-modify-write of the per-channel registers.
// Reset restores the default weights and clears all filter, sum and count registers.
// A stalled output blocks the input stage; samples of absent channels are dropped.
module multichannel_adc_smoother_integrator
  import mcasi_pkg::*;
#(
  parameter int SCALE_BITS    = 8,
  parameter int CHANNELS      = 8,
  parameter int RATE_CHANNELS = 3
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // sample
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,  // channel
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // raw, smoothed, sum, count
  output logic [OUT_TUSER_W-1:0] m_axis_tuser,  // out_channel, is_rate_channel
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [WEIGHT_W-1:0]    cfg_data
);

  localparam int NUM_CH     = (CHANNELS < NUM_INPUT_CH) ? CHANNELS : NUM_INPUT_CH;
  localparam int CH_IDX_W   = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;
  localparam int NUM_RATE   = (RATE_CHANNELS < NUM_CH) ? RATE_CHANNELS : NUM_CH;
  localparam int RATE_DEPTH = (NUM_RATE > 0) ? NUM_RATE : 1;
  localparam int RATE_IDX_W = (RATE_DEPTH > 1) ? $clog2(RATE_DEPTH) : 1;
  localparam int SW         = SCALE_BITS + 1;
  localparam int CW         = (SW > WEIGHT_W) ? SW : WEIGHT_W;
  localparam int AW         = SAMPLE_W + SW + 1;
  localparam int WEIGHT_MAX = (1 << WEIGHT_W) - 1;
  localparam int DEF_W_RAW  = ((1 << SCALE_BITS) * 95) / 100;
  localparam int DEF_W_INT  = (DEF_W_RAW > WEIGHT_MAX) ? WEIGHT_MAX : DEF_W_RAW;

  localparam logic [WEIGHT_W-1:0] DEFAULT_WEIGHT = WEIGHT_W'(DEF_W_INT);
  localparam logic [SW-1:0]       SCALE          = SW'(1) << SCALE_BITS;
  localparam logic [CW-1:0]       SCALE_CW       = CW'(SCALE);
  localparam logic [AW-1:0]       HALF           = AW'(SCALE >> 1);
  localparam logic [CH_W:0]       NUM_CH_L       = (CH_W + 1)'(NUM_CH);
  localparam logic [CH_W:0]       NUM_RATE_L     = (CH_W + 1)'(NUM_RATE);

  logic [WEIGHT_W-1:0] weights [NUM_WEIGHTS];
  logic [SAMPLE_W-1:0] smoothed_store [NUM_CH];
  logic [SUM_W-1:0]    sum_store [RATE_DEPTH];
  logic [COUNT_W-1:0]  count_store [RATE_DEPTH];

  logic                in_valid;
  logic [CH_W-1:0]     in_ch;
  logic [SAMPLE_W-1:0] in_sample;
  logic                out_valid;
  result_t             res;

  logic                ch_ok;
  logic                is_rate;
  logic                out_free;
  logic                in_advance;
  logic                load_out;
  logic [CH_IDX_W-1:0] ch_idx;
  logic [RATE_IDX_W-1:0] rate_idx;
  logic [CW-1:0]       w_ext;
  logic [SW-1:0]       w_sat;
  logic [SW-1:0]       w_inv;
  logic [AW-1:0]       acc;
  logic [AW-1:0]       acc_shift;
  logic [SAMPLE_W-1:0] smoothed_next;
  logic [SUM_W-1:0]    sum_next;
  logic [COUNT_W-1:0]  count_next;

  assign ch_idx     = in_ch[CH_IDX_W-1:0];
  assign rate_idx   = in_ch[RATE_IDX_W-1:0];
  assign ch_ok      = {1'b0, in_ch} < NUM_CH_L;
  assign is_rate    = {1'b0, in_ch} < NUM_RATE_L;
  assign out_free   = !out_valid || m_axis_tready;
  assign in_advance = in_valid && (!ch_ok || out_free);
  assign load_out   = in_valid && ch_ok && out_free;
  assign s_axis_tready = !in_valid || in_advance;

  always_comb begin
    w_ext     = CW'(weights[in_ch]);
    w_sat     = (w_ext > SCALE_CW) ? SCALE : SW'(w_ext);
    w_inv     = SCALE - w_sat;
    acc       = AW'(smoothed_store[ch_idx]) * AW'(w_sat)
              + AW'(in_sample) * AW'(w_inv) + HALF;
    acc_shift = acc >> SCALE_BITS;
    if (acc_shift > AW'(SAMPLE_MAX)) begin
      smoothed_next = SAMPLE_MAX;
    end else begin
      smoothed_next = acc_shift[SAMPLE_W-1:0];
    end
    sum_next   = sum_store[rate_idx] + SUM_W'(in_sample);
    count_next = count_store[rate_idx] + COUNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_WEIGHTS; i++) begin
        weights[i] <= DEFAULT_WEIGHT;
      end
      for (int i = 0; i < NUM_CH; i++) begin
        smoothed_store[i] <= '0;
      end
      for (int i = 0; i < RATE_DEPTH; i++) begin
        sum_store[i]   <= '0;
        count_store[i] <= '0;
      end
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid <= 1'b1;
      end else if (in_advance) begin
        in_valid <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        weights[cfg_index] <= cfg_data;
      end
      if (load_out) begin
        smoothed_store[ch_idx] <= smoothed_next;
        if (is_rate) begin
          sum_store[rate_idx]   <= sum_next;
          count_store[rate_idx] <= count_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_ch     <= s_axis_tuser[CH_W-1:0];
      in_sample <= s_axis_tdata[SAMPLE_W-1:0];
    end
    if (load_out) begin
      res.channel  <= in_ch;
      res.raw      <= in_sample;
      res.smoothed <= smoothed_next;
      res.rate     <= is_rate;
      res.sum      <= is_rate ? sum_next : '0;
      res.count    <= is_rate ? count_next : '0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {res.count, res.sum, res.smoothed, res.raw};
  assign m_axis_tuser  = {res.rate, res.channel};

  a_rate_channel_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.rate |-> {1'b0, res.channel} < NUM_RATE_L)
    else $error("rate flag set on a channel without a sum");

  a_plain_channel_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !res.rate |-> res.sum == '0 && res.count == '0)
    else $error("sum or count nonzero on a channel without a sum");

  a_channel_present: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> {1'b0, res.channel} < NUM_CH_L)
    else $error("result for an absent channel");

  a_store_matches_result: assert property (@(posedge clk) disable iff (rst)
    load_out |=> smoothed_store[$past(ch_idx)] == res.smoothed)
    else $error("filter register and result disagree");

endmodule

>>> tb/multichannel_adc_smoother_integrator_test.sv
`timescale 1ns / 1ps

module multichannel_adc_smoother_integrator_test;
  import mcasi_pkg::*;

  localparam int SCALE_BITS     = 8;
  localparam int CHANNELS       = 8;
  localparam int RATE_CHANNELS  = 3;
  localparam int SCALE          = 1 << SCALE_BITS;
  localparam int DEFAULT_WEIGHT = SCALE * 95 / 100;
  localparam int WEIGHT_MAX     = (1 << WEIGHT_W) - 1;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] sample;
  } sample_item_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // sample
  logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;   // channel
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // raw, smoothed, sum, count
  logic [OUT_TUSER_W-1:0] m_axis_tuser;        // out_channel, is_rate_channel
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [WEIGHT_W-1:0]    cfg_data = '0;

  logic [WEIGHT_W-1:0] weight_reg   [NUM_WEIGHTS];
  logic [SAMPLE_W-1:0] filtered_val [CHANNELS];
  logic [SUM_W-1:0]    sum_acc      [CHANNELS];
  logic [COUNT_W-1:0]  sample_tally [CHANNELS];

  sample_item_t pending_samples[$];
  result_t      expected_results[$];

  int  items_queued = 0;
  int  items_accepted = 0;
  int  results_checked = 0;
  int  weight_writes = 0;
  int  fail_count = 0;
  int  cycle_count = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  hold_request = 0;
  int  hold_left = 0;
  bit  in_taken = 1'b0;

  multichannel_adc_smoother_integrator #(
    .SCALE_BITS(SCALE_BITS),
    .CHANNELS(CHANNELS),
    .RATE_CHANNELS(RATE_CHANNELS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  function automatic result_t advance_channel(sample_item_t it);
    result_t     r;
    logic [63:0] w;
    logic [63:0] acc;
    int          ch;
    ch = it.channel;
    w = weight_reg[ch];
    if (w > SCALE) begin
      w = SCALE;
    end
    acc = (64'(filtered_val[ch]) * w + 64'(it.sample) * (64'(SCALE) - w)
           + 64'(SCALE / 2)) >> SCALE_BITS;
    if (acc > 64'hFFFF) begin
      acc = 64'hFFFF;
    end
    filtered_val[ch] = acc[SAMPLE_W-1:0];
    r = '0;
    r.channel = it.channel;
    r.raw = it.sample;
    r.smoothed = acc[SAMPLE_W-1:0];
    r.rate = (ch < RATE_CHANNELS);
    if (r.rate) begin
      sum_acc[ch] = sum_acc[ch] + 64'(it.sample);
      sample_tally[ch] = sample_tally[ch] + 1;
      r.sum = sum_acc[ch];
      r.count = sample_tally[ch];
    end
    return r;
  endfunction

  function automatic int pick_gap(int pct);
    if ($urandom_range(0, 99) >= pct) begin
      return 0;
    end
    if ($urandom_range(0, 9) < 8) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_weight();
    case ($urandom_range(0, 11))
      0: return 0;
      1: return 1;
      2: return SCALE;
      3: return SCALE + 1;
      4: return WEIGHT_MAX;
      5: return SCALE - 1;
      6: return DEFAULT_WEIGHT;
      default: return $urandom_range(0, WEIGHT_MAX);
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return SAMPLE_MAX;
      2, 3, 4: return SAMPLE_W'($urandom) & 16'hFFFC;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic void log_failure(string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endfunction

  task automatic queue_sample(int ch, logic [SAMPLE_W-1:0] value);
    sample_item_t it;
    it.channel = CH_W'(ch);
    it.sample = value;
    pending_samples.push_back(it);
    items_queued++;
  endtask

  task automatic set_weight(int idx, int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data <= WEIGHT_W'(value);
    weight_reg[idx] = WEIGHT_W'(value);
    weight_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every queued sample has been taken and its result checked.
  task automatic wait_idle();
    @(negedge clk);
    while (items_accepted != items_queued || expected_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (3) @(negedge clk);
  endtask

  always @(negedge clk) begin : sample_driver
    sample_item_t it;
    if (!rst && (!s_axis_tvalid || in_taken)) begin
      in_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        it = pending_samples.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= it.sample;
        s_axis_tuser <= it.channel;
        send_gap = pick_gap(send_idle_pct);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : result_sink
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      recv_gap = pick_gap(recv_idle_pct);
    end
  end

  always @(posedge clk) begin : monitor
    result_t      got;
    result_t      want;
    sample_item_t it;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.channel = m_axis_tuser[CH_W-1:0];
        got.rate = m_axis_tuser[CH_W];
        got.raw = m_axis_tdata[15:0];
        got.smoothed = m_axis_tdata[31:16];
        got.sum = m_axis_tdata[95:32];
        got.count = m_axis_tdata[127:96];
        results_checked++;
        if (expected_results.size() == 0) begin
          log_failure($sformatf("unexpected result on channel %0d", got.channel));
        end else begin
          want = expected_results.pop_front();
          if (got.channel !== want.channel || got.rate !== want.rate ||
              got.raw !== want.raw || got.smoothed !== want.smoothed ||
              got.sum !== want.sum || got.count !== want.count) begin
            log_failure($sformatf({"mismatch: expected ch=%0d rate=%b raw=%h ",
              "smoothed=%h sum=%h count=%h, got ch=%0d rate=%b raw=%h ",
              "smoothed=%h sum=%h count=%h"},
              want.channel, want.rate, want.raw, want.smoothed, want.sum, want.count,
              got.channel, got.rate, got.raw, got.smoothed, got.sum, got.count));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_taken = 1'b1;
        items_accepted++;
        it.channel = s_axis_tuser;
        it.sample = s_axis_tdata;
        expected_results.push_back(advance_channel(it));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int ch;
    int n;
    int phase;
    for (ch = 0; ch < NUM_WEIGHTS; ch++) begin
      weight_reg[ch] = WEIGHT_W'(DEFAULT_WEIGHT);
    end
    for (ch = 0; ch < CHANNELS; ch++) begin
      filtered_val[ch] = '0;
      sum_acc[ch] = '0;
      sample_tally[ch] = '0;
    end
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Reset weights, full-scale, zero and patterned samples, every channel.
    send_idle_pct = 30;
    recv_idle_pct = 30;
    queue_sample(0, SAMPLE_MAX);
    queue_sample(0, SAMPLE_MAX);
    queue_sample(1, '0);
    queue_sample(2, SAMPLE_MAX);
    queue_sample(3, 16'h8000);
    queue_sample(4, 16'hFFFC);
    queue_sample(5, 16'h0004);
    queue_sample(6, 16'h5555);
    queue_sample(7, 16'hAAAA);
    wait_idle();

    // Extreme weights, including ones above full scale that must saturate.
    set_weight(0, 0);
    set_weight(1, SCALE);
    set_weight(2, WEIGHT_MAX);
    set_weight(3, 300);
    set_weight(4, 1);
    set_weight(5, SCALE - 1);
    set_weight(6, SCALE / 2);
    set_weight(7, SCALE + 1);
    for (ch = 0; ch < CHANNELS; ch++) begin
      queue_sample(ch, SAMPLE_MAX);
    end
    for (ch = 0; ch < CHANNELS; ch++) begin
      queue_sample(ch, '0);
    end
    wait_idle();

    for (phase = 0; phase < 6; phase++) begin
      for (ch = 0; ch < NUM_WEIGHTS; ch++) begin
        set_weight(ch, pick_weight());
      end
      send_idle_pct = (phase == 2) ? 0 : $urandom_range(10, 50);
      recv_idle_pct = (phase == 2) ? 0 : $urandom_range(10, 50);
      if (phase == 3) begin
        // Long receiver stall with the sender pushing back to back.
        send_idle_pct = 0;
        @(posedge clk);
        hold_request = 250;
      end
      for (n = 0; n < 90; n++) begin
        queue_sample($urandom_range(0, CHANNELS - 1), pick_sample());
      end
      wait_idle();
    end

    repeat (8) @(negedge clk);
    while (expected_results.size() > 0) begin
      void'(expected_results.pop_front());
      log_failure("expected result never arrived");
    end

    $display("Covered %0d samples on %0d channels, %0d results checked, %0d weight writes.",
             items_accepted, CHANNELS, results_checked, weight_writes);
    $display("Weights spanned zero, full scale and saturating values; %0d failures.",
             fail_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> multichannel_adc_smoother_integrator.f
src/mcasi_pkg.sv
src/multichannel_adc_smoother_integrator.sv
tb/multichannel_adc_smoother_integrator_test.sv
